// ----- rtl/ttnf_pkg.sv -----
// Shared types and constants for the tuning-table note-to-frequency converter.
package ttnf_pkg;

  // Stream and configuration port widths.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Command codes carried on s_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_GRADES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_KEY = 3'd4;

  // Register reset values.
  localparam logic [6:0] NUM_GRADES_RST = 7'd12;
  localparam logic [31:0] PERIOD_INTERVAL_RST = 32'd33554432;
  localparam logic [31:0] INVERSE_INTERVAL_RST = 32'd8388608;
  localparam logic [31:0] BASE_FREQUENCY_RST = 32'd17145895;
  localparam logic [6:0] BASE_KEY_RST = 7'd60;

  // Fixed-point constants for Q8.24 products.
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [64:0] HALF_Q24 = 65'h0_0000_0000_0080_0000;

  // The note distance is seven bits, so the divider runs seven steps.
  localparam int DIV_STEPS = 7;

endpackage

// ----- rtl/table_tuning_note_to_freq.sv -----
// Top level of the tuning-table note-to-frequency converter.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tdata: note, entry_index, entry_ratio; s_tuser: cmd
//  m_*       out        m_tvalid/m_tready    m_tdata: frequency; m_tuser: saturated
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load item gives no result. A convert item passes from acceptance to the
// result register through seven divider steps, a fix-up step, a multiply
// and round pair for each period of the note on the shared 32x32 multiplier
// (the period count is 0 to 127), a table read and two more multiply/round
// pairs. Reset is synchronous and returns the control state and the
// configuration registers to their reset values; the ratio table is not
// cleared. A finished result waits in the output register while the
// block goes on accepting items; a new result waits in its last round stage
// until the output register is free.
module table_tuning_note_to_freq
  import ttnf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata from bit 0 up: note[6:0], entry_index[12:7], entry_ratio[44:13], zero fill.
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // s_tuser: cmd.
  input  logic                  s_tuser,
  // Result items.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata from bit 0 up: frequency[31:0].
  output logic [M_TDATA_W-1:0]  m_tdata,
  // m_tuser: saturated.
  output logic                  m_tuser,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_W = 9'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_POW_MUL,
    ST_POW_RND,
    ST_RD,
    ST_RAT_MUL,
    ST_RAT_RND,
    ST_BF_MUL,
    ST_BF_RND
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0]  num_grades;
  logic [31:0] period_interval;
  logic [31:0] inverse_interval;
  logic [31:0] base_frequency;
  logic [6:0]  base_key;

  // Datapath registers.
  logic [6:0]  g_reg;
  logic        neg;
  logic [6:0]  rem;
  logic [6:0]  quo;
  logic [2:0]  step;
  logic [6:0]  grade;
  logic [6:0]  count;
  logic [31:0] acc;
  logic [63:0] prod;
  logic        sat;

  // Ratio table, one synchronous memory.
  logic [31:0] ratio_mem [TABLE_DEPTH];
  logic [31:0] rdata;

  // Input field extraction.
  logic [6:0]  in_note;
  logic [5:0]  in_index;
  logic [31:0] in_ratio;
  assign in_note  = s_tdata[6:0];
  assign in_index = s_tdata[12:7];
  assign in_ratio = s_tdata[44:13];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = s_tvalid && s_tready;

  // Effective grade count: num_grades clamped to one through the table depth.
  logic [6:0] g_eff;
  always_comb begin
    if (num_grades == 7'd0) begin
      g_eff = 7'd1;
    end else if ({2'b00, num_grades} > DEPTH_W) begin
      g_eff = 7'(DEPTH_W);
    end else begin
      g_eff = num_grades;
    end
  end

  // One restoring divider step: shift in the next dividend bit and subtract.
  logic [7:0] rem_sh;
  logic [7:0] rem_diff;
  logic [6:0] rem_next;
  logic [6:0] quo_next;
  always_comb begin
    rem_sh   = {rem, quo[6]};
    rem_diff = rem_sh - {1'b0, g_reg};
    if (rem_sh >= {1'b0, g_reg}) begin
      rem_next = rem_diff[6:0];
      quo_next = {quo[5:0], 1'b1};
    end else begin
      rem_next = rem_sh[6:0];
      quo_next = {quo[5:0], 1'b0};
    end
  end

  // Degree and period count from quotient and remainder. Below the base key
  // the count rounds up and the degree wraps back from the top of the scale.
  logic [6:0] grade_calc;
  logic [6:0] count_calc;
  always_comb begin
    if (neg && (rem != 7'd0)) begin
      grade_calc = g_reg - rem;
      count_calc = quo + 7'd1;
    end else if (neg) begin
      grade_calc = 7'd0;
      count_calc = quo;
    end else begin
      grade_calc = rem;
      count_calc = quo;
    end
  end

  // Shared multiplier operands.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    case (state)
      ST_POW_MUL: begin
        mul_a = acc;
        mul_b = neg ? inverse_interval : period_interval;
      end
      ST_RAT_MUL: begin
        mul_a = rdata;
        mul_b = acc;
      end
      ST_BF_MUL: begin
        mul_a = acc;
        mul_b = base_frequency;
      end
      default: begin
        mul_a = acc;
        mul_b = base_frequency;
      end
    endcase
  end

  // Round half up, drop 24 fraction bits and clamp to 32 bits.
  logic [64:0] rnd_sum;
  logic [40:0] rnd_sh;
  logic [31:0] rnd_val;
  logic        rnd_sat;
  always_comb begin
    rnd_sum = {1'b0, prod} + HALF_Q24;
    rnd_sh  = rnd_sum[64:24];
    rnd_sat = |rnd_sh[40:32];
    rnd_val = rnd_sat ? 32'hFFFF_FFFF : rnd_sh[31:0];
  end

  // Table write and registered read.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  assign wr_en   = in_fire && (s_tuser == CMD_LOAD) && ({3'b000, in_index} < DEPTH_W);
  assign wr_addr = AW'(in_index);
  assign rd_addr = AW'(grade);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ratio_mem[wr_addr] <= in_ratio;
    end
    rdata <= ratio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      num_grades       <= NUM_GRADES_RST;
      period_interval  <= PERIOD_INTERVAL_RST;
      inverse_interval <= INVERSE_INTERVAL_RST;
      base_frequency   <= BASE_FREQUENCY_RST;
      base_key         <= BASE_KEY_RST;
    end else begin
      // In the last round stage a taken result is replaced by the new one
      // below, so the output register is only emptied in the other states.
      if (m_tvalid && m_tready && (state != ST_BF_RND)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_NUM_GRADES:       num_grades       <= cfg_data[6:0];
          REG_PERIOD_INTERVAL:  period_interval  <= cfg_data;
          REG_INVERSE_INTERVAL: inverse_interval <= cfg_data;
          REG_BASE_FREQUENCY:   base_frequency   <= cfg_data;
          REG_BASE_KEY:         base_key         <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_fire && (s_tuser == CMD_CONVERT)) begin
            g_reg <= g_eff;
            neg   <= (in_note < base_key);
            quo   <= (in_note < base_key) ? (base_key - in_note) : (in_note - base_key);
            rem   <= 7'd0;
            step  <= 3'd0;
            sat   <= 1'b0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + 3'd1;
          if (step == 3'(DIV_STEPS - 1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          grade <= grade_calc;
          count <= count_calc;
          acc   <= ONE_Q24;
          state <= (count_calc == 7'd0) ? ST_RD : ST_POW_MUL;
        end
        ST_POW_MUL: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_POW_RND;
        end
        ST_POW_RND: begin
          acc   <= rnd_val;
          sat   <= sat | rnd_sat;
          count <= count - 7'd1;
          state <= (count == 7'd1) ? ST_RD : ST_POW_MUL;
        end
        ST_RD: begin
          state <= ST_RAT_MUL;
        end
        ST_RAT_MUL: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_RAT_RND;
        end
        ST_RAT_RND: begin
          acc   <= rnd_val;
          sat   <= sat | rnd_sat;
          state <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_BF_RND;
        end
        ST_BF_RND: begin
          // Hand over only when the output register is empty or emptying.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= rnd_val;
            m_tuser  <= sat | rnd_sat;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The partial remainder always stays below the divisor.
  a_rem_below_g: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < g_reg))
    else $error("divider remainder reached the divisor");

  // The degree read from the table is always inside the scale.
  a_grade_in_scale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (grade < g_reg))
    else $error("scale degree outside the grade count");

  // A period multiply is only started while periods remain.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW_MUL) |-> (count != 7'd0))
    else $error("period multiply with zero count");

  // Table writes happen only while no conversion is in flight.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE))
    else $error("table write during a conversion");

  // A result handed over while the output register was full would be lost.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BF_RND && m_tvalid && !m_tready) |=> (state == ST_BF_RND))
    else $error("result left the round stage while output was blocked");

endmodule
